FILE: hw/rtl/pmpd_pkg.sv
// package for the ps/2 mouse packet decoder
// packet record, byte position, mode codes, header bit positions and the movement helper; no dependencies
`timescale 1ns / 1ps

package pmpd_pkg;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [PADDR_W-3:0] REG_MODE = 1'b0;

	localparam logic [1:0] MODE_STD     = 2'd0;
	localparam logic [1:0] MODE_SCROLL  = 2'd1;
	localparam logic [1:0] MODE_FIVEBTN = 2'd2;

	localparam int unsigned SYNC_BIT   = 3;
	localparam int unsigned XSIGN_BIT  = 4;
	localparam int unsigned YSIGN_BIT  = 5;
	localparam int unsigned XOVF_BIT   = 6;
	localparam int unsigned YOVF_BIT   = 7;
	localparam int unsigned BTN_LEFT   = 0;
	localparam int unsigned BTN_RIGHT  = 1;
	localparam int unsigned BTN_MIDDLE = 2;

	typedef enum logic [1:0] {
		POS_HEADER,
		POS_X,
		POS_Y,
		POS_FOURTH
	} byte_pos_t;

	typedef struct packed {
		logic [7:0] header;
		logic [7:0] x_data;
		logic [7:0] y_data;
		logic [7:0] fourth;
		logic       scroll_en;
	} packet_t;

	function automatic logic signed [8:0] movement(input logic [7:0] b, input logic sign);
		logic signed [8:0] v;
		v = {(sign && (b != 8'd0)), b};
		return v;
	endfunction

endpackage

FILE: hw/rtl/ps2_mouse_packet_decoder_unit.sv
// top level of the ps/2 mouse packet decoder with its mode register
// depends on pmpd_pkg, pmpd_front, pmpd_queue, pmpd_back
`timescale 1ns / 1ps

// usage
// input channel: one raw mouse byte per transfer on data_byte (in_valid / in_stall)
// output channel: one decoded packet per transfer (out_valid / out_stall) carrying
//   move_x, move_y, the three button flags and scroll_up / scroll_down
// apb port: mode register at byte address 0 (0 standard, 1 scroll wheel,
//   2 five button); write it only while no packet is in flight
// throughput: one byte per cycle while the packet queue is not full (in_stall low)
// a packet's last byte is written into the packet queue, from which the back end loads
//   it into the output register that drives out_valid, unless the output is stalled
// reset clears the byte position, the queue, the output valid and mode
// a stalled receiver holds the output; bytes are still taken until the two-entry
//   packet queue fills, then in_stall goes high

module ps2_mouse_packet_decoder_unit
	import pmpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [8:0]  move_x,
	output logic signed [8:0]  move_y,
	output logic               left_pressed,
	output logic               right_pressed,
	output logic               middle_pressed,
	output logic               scroll_up,
	output logic               scroll_down,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [1:0] mode_q;
	logic       q_full;
	logic       push;
	packet_t    push_pkt;
	logic       pop;
	logic       head_valid;
	packet_t    head_pkt;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_MODE);
	assign prdata  = reg_sel ? PDATA_W'(mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STD;
		end else if (psel && penable && pwrite && reg_sel) begin
			mode_q <= pwdata[1:0];
		end
	end

	pmpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.mode      (mode_q),
		.q_full    (q_full),
		.push      (push),
		.push_pkt  (push_pkt)
	);

	pmpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_pkt   (push_pkt),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_pkt   (head_pkt)
	);

	pmpd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_pkt       (head_pkt),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.move_x         (move_x),
		.move_y         (move_y),
		.left_pressed   (left_pressed),
		.right_pressed  (right_pressed),
		.middle_pressed (middle_pressed),
		.scroll_up      (scroll_up),
		.scroll_down    (scroll_down)
	);

endmodule

FILE: hw/rtl/pmpd_front.sv
// front end: takes raw bytes and assembles complete packets
// depends on pmpd_pkg
`timescale 1ns / 1ps

module pmpd_front
	import pmpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic [1:0] mode,
	input  logic       q_full,
	output logic       push,
	output packet_t    push_pkt
);

	byte_pos_t  pos_q, pos_next;
	logic [7:0] header_q;
	logic [7:0] x_q;
	logic [7:0] y_q;
	logic       take;
	logic       four_byte;

	assign in_stall  = q_full;
	assign take      = in_valid && !q_full;
	assign four_byte = (mode == MODE_SCROLL) || (mode == MODE_FIVEBTN);

	// next position
	always_comb begin
		pos_next = pos_q;
		if (take) begin
			case (pos_q)
				POS_HEADER: pos_next = data_byte[SYNC_BIT] ? POS_X : POS_HEADER;
				POS_X:      pos_next = POS_Y;
				POS_Y:      pos_next = four_byte ? POS_FOURTH : POS_HEADER;
				POS_FOURTH: pos_next = POS_HEADER;
				default:    pos_next = POS_HEADER;
			endcase
		end
	end

	// packet completion
	always_comb begin
		push               = 1'b0;
		push_pkt.header    = header_q;
		push_pkt.x_data    = x_q;
		push_pkt.y_data    = y_q;
		push_pkt.fourth    = 8'd0;
		push_pkt.scroll_en = 1'b0;
		case (pos_q)
			POS_Y: begin
				push_pkt.y_data = data_byte;
				push            = take && !four_byte;
			end
			POS_FOURTH: begin
				push_pkt.fourth    = data_byte;
				push_pkt.scroll_en = (mode == MODE_SCROLL);
				push               = take;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HEADER;
		end else begin
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			case (pos_q)
				POS_HEADER: header_q <= data_byte;
				POS_X:      x_q      <= data_byte;
				POS_Y:      y_q      <= data_byte;
				default:    ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/pmpd_queue.sv
// short packet queue between front and back end
// depends on pmpd_pkg
`timescale 1ns / 1ps

module pmpd_queue
	import pmpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  packet_t push_pkt,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output packet_t head_pkt
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	packet_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_pkt   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_pkt;
		end
	end

endmodule

FILE: hw/rtl/pmpd_back.sv
// back end: decodes a packet into movement, buttons and scroll
// depends on pmpd_pkg
`timescale 1ns / 1ps

module pmpd_back
	import pmpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  packet_t           head_pkt,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [8:0] move_x,
	output logic signed [8:0] move_y,
	output logic              left_pressed,
	output logic              right_pressed,
	output logic              middle_pressed,
	output logic              scroll_up,
	output logic              scroll_down
);

	logic              valid_q;
	logic signed [8:0] mx_q, my_q;
	logic              left_q, right_q, middle_q, up_q, down_q;
	logic signed [8:0] mx, my;
	logic              ovf;
	logic              scroll_act;

	assign pop = head_valid && (!valid_q || !out_stall);

	always_comb begin
		ovf        = head_pkt.header[XOVF_BIT] || head_pkt.header[YOVF_BIT];
		mx         = ovf ? 9'sd0 : movement(head_pkt.x_data, head_pkt.header[XSIGN_BIT]);
		my         = ovf ? 9'sd0 : movement(head_pkt.y_data, head_pkt.header[YSIGN_BIT]);
		scroll_act = head_pkt.scroll_en && (head_pkt.fourth != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mx_q     <= mx;
			my_q     <= my;
			left_q   <= head_pkt.header[BTN_LEFT];
			right_q  <= head_pkt.header[BTN_RIGHT];
			middle_q <= head_pkt.header[BTN_MIDDLE];
			up_q     <= scroll_act && head_pkt.fourth[7];
			down_q   <= scroll_act && !head_pkt.fourth[7];
		end
	end

	assign out_valid      = valid_q;
	assign move_x         = mx_q;
	assign move_y         = my_q;
	assign left_pressed   = left_q;
	assign right_pressed  = right_q;
	assign middle_pressed = middle_q;
	assign scroll_up      = up_q;
	assign scroll_down    = down_q;

endmodule
